// File: rtl/lapp_pkg.sv
// Shared types, codes and constants of the looping audio packet pacer.
package lapp_pkg;

	localparam int unsigned MODE_W    = 2;
	localparam int unsigned SPEED_W   = 8;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned OFFSET_W  = 29;
	localparam int unsigned AMOUNT_W  = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 24;
	localparam int unsigned RATE_W    = 18;
	localparam int unsigned CHAN_W    = 4;
	localparam int unsigned DEPTH_W   = 6;

	localparam logic [MODE_W-1:0] OP_TICK    = 2'd0;
	localparam logic [MODE_W-1:0] OP_PAUSE   = 2'd1;
	localparam logic [MODE_W-1:0] OP_RESTART = 2'd2;
	localparam logic [MODE_W-1:0] OP_SPEED   = 2'd3;

	localparam logic [KIND_W-1:0] KIND_START_NAMED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START       = 2'd1;
	localparam logic [KIND_W-1:0] KIND_AUDIO       = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_SAMPLES = 2'd3;

	localparam logic [RATE_W-1:0]   RST_SAMPLE_RATE   = 18'd44100;
	localparam logic [CHAN_W-1:0]   RST_CHANNELS      = 4'd2;
	localparam logic [DEPTH_W-1:0]  RST_BIT_DEPTH     = 6'd16;
	localparam logic [AMOUNT_W-1:0] RST_TRACK_SAMPLES = 24'd1;

	localparam logic [SPEED_W-1:0] SPEED_NORMAL = 8'd100;
	localparam logic [SPEED_W-1:0] SPEED_MIN    = 8'd75;
	localparam logic [SPEED_W-1:0] SPEED_MAX    = 8'd150;

	localparam int unsigned RATE_SCALE = 100000;

	localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;

	typedef struct packed {
		logic [MODE_W-1:0]  op;
		logic [SPEED_W-1:0] speed;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [OFFSET_W-1:0] byte_offset;
		logic [AMOUNT_W-1:0] amount;
		logic                last;
	} result_t;

	function automatic logic [AMOUNT_W-1:0] sat_amount(input logic [OFFSET_W-1:0] v);
		logic [AMOUNT_W-1:0] r;
		if (v > OFFSET_W'(AMOUNT_MAX)) begin
			r = AMOUNT_MAX;
		end else begin
			r = v[AMOUNT_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/lapp_fifo.sv
// Small first-in first-out queue built from a register array.
module lapp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: rtl/lapp_front.sv
// Front end: decodes an incoming item into a command and saturates the speed.
module lapp_front (
	input  logic [lapp_pkg::MODE_W-1:0]  mode,
	input  logic [lapp_pkg::SPEED_W-1:0] speed_percent,
	output lapp_pkg::cmd_t               cmd
);

	always_comb begin
		cmd.speed = speed_percent;
		if (speed_percent < lapp_pkg::SPEED_MIN) begin
			cmd.speed = lapp_pkg::SPEED_MIN;
		end else if (speed_percent > lapp_pkg::SPEED_MAX) begin
			cmd.speed = lapp_pkg::SPEED_MAX;
		end
		unique case (mode)
			lapp_pkg::OP_PAUSE:   cmd.op = lapp_pkg::OP_PAUSE;
			lapp_pkg::OP_RESTART: cmd.op = lapp_pkg::OP_RESTART;
			lapp_pkg::OP_SPEED:   cmd.op = lapp_pkg::OP_SPEED;
			default:              cmd.op = lapp_pkg::OP_TICK;
		endcase
	end

endmodule

// File: rtl/lapp_back.sv
// Back end: packet size computation, tick splitting and result emission.
module lapp_back #(
	parameter int unsigned MAX_PACKET_BYTES = 4096,
	parameter int unsigned PERIOD_MS        = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lapp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lapp_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  lapp_pkg::cmd_t                  cmd,
	input  logic                            cmd_valid,
	output logic                            cmd_pop,
	output lapp_pkg::result_t               res,
	output logic                            res_push,
	input  logic                            res_full
);

	localparam int unsigned QW    = $clog2(MAX_PACKET_BYTES + 1);
	localparam int unsigned DW    = QW + 17;
	localparam int unsigned CW    = $clog2(QW);
	localparam int unsigned PERW  = $clog2(PERIOD_MS + 1);
	localparam int unsigned P1W   = lapp_pkg::RATE_W + lapp_pkg::SPEED_W;
	localparam int unsigned P2W   = P1W + 7;
	localparam int unsigned P3W   = P2W + PERW;
	localparam int unsigned FBW   = lapp_pkg::CHAN_W + lapp_pkg::DEPTH_W;
	localparam int unsigned TRW   = lapp_pkg::AMOUNT_W + FBW;
	localparam int unsigned OW    = lapp_pkg::OFFSET_W;
	localparam logic [63:0] LIMIT = 64'(MAX_PACKET_BYTES + 1) * 64'(lapp_pkg::RATE_SCALE);
	localparam int unsigned XW    = $clog2(LIMIT);
	localparam int unsigned SH    = XW + $clog2(lapp_pkg::RATE_SCALE);
	localparam int unsigned MW    = XW + 1;
	localparam int unsigned RPW   = XW + MW;
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(lapp_pkg::RATE_SCALE) - 64'd1)
	                                / 64'(lapp_pkg::RATE_SCALE);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RC0  = 4'd1;
	localparam logic [3:0] ST_RC1  = 4'd2;
	localparam logic [3:0] ST_RC2  = 4'd3;
	localparam logic [3:0] ST_RC3  = 4'd4;
	localparam logic [3:0] ST_DIV2 = 4'd6;
	localparam logic [3:0] ST_TICK = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	localparam logic [1:0] STEP_TS0  = 2'd0;
	localparam logic [1:0] STEP_SEG  = 2'd1;
	localparam logic [1:0] STEP_TS1  = 2'd2;
	localparam logic [1:0] STEP_HEAD = 2'd3;

	logic [3:0]                          state_q;
	logic [1:0]                          step_q;
	logic                                pend_q;
	logic                                paused_q;
	logic [lapp_pkg::SPEED_W-1:0]        speed_q;
	logic [OW-1:0]                       read_index_q;
	logic [lapp_pkg::RATE_W-1:0]         sample_rate_q;
	logic [lapp_pkg::CHAN_W-1:0]         channels_q;
	logic [lapp_pkg::DEPTH_W-1:0]        bit_depth_q;
	logic [lapp_pkg::AMOUNT_W-1:0]       track_q;

	logic [6:0]                          bpf_q;
	logic [P1W-1:0]                      prod1_q;
	logic [P2W-1:0]                      prod2_q;
	logic [P3W-1:0]                      prod3_q;
	logic [TRW-1:0]                      tot_raw_q;
	logic [OW-1:0]                       total_q;
	logic [QW-1:0]                       bytes_q;
	logic [QW-1:0]                       packet_size_q;
	logic [DW-1:0]                       div_rem_q;
	logic [DW-1:0]                       div_den_q;
	logic [QW-1:0]                       div_quo_q;
	logic [CW-1:0]                       div_cnt_q;
	logic [OW-1:0]                       off_q;
	logic [lapp_pkg::AMOUNT_W-1:0]       seg_amt_q;
	logic [lapp_pkg::AMOUNT_W-1:0]       head_amt_q;
	logic                                fits_q;

	logic [FBW-1:0]                      frame_bits;
	logic [TRW-3-1:0]                    tot_bytes;
	logic [DW-1:0]                       bpf_den;
	logic                                rc_clamp;
	logic [RPW-1:0]                      rc_prod;
	logic [QW-1:0]                       rc_bytes;
	logic                                div_ge;
	logic [DW-1:0]                       div_rem_nxt;
	logic [QW-1:0]                       div_quo_nxt;
	logic                                div_last;
	logic [OW:0]                         tk_sum;
	logic                                tk_fits;
	logic [OW-1:0]                       tk_tail;
	logic [OW:0]                         tk_diff;
	logic [OW-1:0]                       tk_head;
	logic [OW-1:0]                       tk_next;
	logic                                emit_done;

	assign frame_bits = FBW'(channels_q) * FBW'(bit_depth_q);
	assign tot_bytes  = tot_raw_q[TRW-1:3];
	assign bpf_den    = DW'({bpf_q, {(QW - 1){1'b0}}});

	assign rc_clamp = (64'(prod3_q) >= LIMIT);
	assign rc_prod  = RPW'(prod3_q[XW-1:0]) * RPW'(RECIP[MW-1:0]);
	assign rc_bytes = rc_clamp ? QW'(MAX_PACKET_BYTES) : rc_prod[SH +: QW];

	assign div_ge      = (div_rem_q >= div_den_q);
	assign div_rem_nxt = div_ge ? div_rem_q - div_den_q : div_rem_q;
	assign div_quo_nxt = {div_quo_q[QW-2:0], div_ge};
	assign div_last    = (div_cnt_q == '0);

	assign tk_sum  = (OW + 1)'(read_index_q) + (OW + 1)'(packet_size_q);
	assign tk_fits = (tk_sum <= (OW + 1)'(total_q));
	assign tk_tail = (read_index_q < total_q) ? total_q - read_index_q : '0;
	assign tk_diff = tk_sum - (OW + 1)'(total_q);
	assign tk_head = (tk_diff > (OW + 1)'(total_q)) ? total_q : tk_diff[OW-1:0];
	assign tk_next = tk_fits ? tk_sum[OW-1:0] : tk_head;

	assign cmd_pop   = (state_q == ST_IDLE) && !pend_q && cmd_valid;
	assign res_push  = (state_q == ST_EMIT) && !res_full;
	assign emit_done = ((step_q == STEP_SEG) && fits_q) || (step_q == STEP_HEAD);

	always_comb begin
		res = '0;
		case (step_q)
			STEP_TS0: begin
				res.kind   = lapp_pkg::KIND_START_NAMED;
				res.amount = track_q;
			end
			STEP_SEG: begin
				res.kind        = lapp_pkg::KIND_AUDIO;
				res.byte_offset = off_q;
				res.amount      = seg_amt_q;
				res.last        = fits_q;
			end
			STEP_TS1: begin
				res.kind   = lapp_pkg::KIND_START;
				res.amount = track_q;
			end
			default: begin
				res.kind   = lapp_pkg::KIND_AUDIO;
				res.amount = head_amt_q;
				res.last   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= STEP_SEG;
			pend_q        <= 1'b1;
			paused_q      <= 1'b0;
			speed_q       <= lapp_pkg::SPEED_NORMAL;
			read_index_q  <= '0;
			sample_rate_q <= lapp_pkg::RST_SAMPLE_RATE;
			channels_q    <= lapp_pkg::RST_CHANNELS;
			bit_depth_q   <= lapp_pkg::RST_BIT_DEPTH;
			track_q       <= lapp_pkg::RST_TRACK_SAMPLES;
		end else begin
			if (cfg_we) begin
				pend_q <= 1'b1;
				unique case (cfg_index)
					lapp_pkg::REG_SAMPLE_RATE:
						sample_rate_q <= cfg_data[lapp_pkg::RATE_W-1:0];
					lapp_pkg::REG_CHANNELS:
						channels_q <= cfg_data[lapp_pkg::CHAN_W-1:0];
					lapp_pkg::REG_BIT_DEPTH:
						bit_depth_q <= cfg_data[lapp_pkg::DEPTH_W-1:0];
					default:
						track_q <= cfg_data[lapp_pkg::AMOUNT_W-1:0];
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pend_q) begin
						if (!cfg_we) begin
							pend_q <= 1'b0;
						end
						state_q <= ST_RC0;
					end else if (cmd_valid) begin
						unique case (cmd.op)
							lapp_pkg::OP_PAUSE:   paused_q <= !paused_q;
							lapp_pkg::OP_RESTART: read_index_q <= '0;
							lapp_pkg::OP_SPEED: begin
								speed_q <= cmd.speed;
								pend_q  <= 1'b1;
							end
							default: begin
								if (!paused_q) begin
									state_q <= ST_TICK;
								end
							end
						endcase
					end
				end
				ST_RC0: state_q <= ST_RC1;
				ST_RC1: state_q <= ST_RC2;
				ST_RC2: state_q <= ST_RC3;
				ST_RC3: begin
					if (bpf_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					read_index_q <= tk_next;
					step_q       <= (read_index_q == '0) ? STEP_TS0 : STEP_SEG;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!res_full) begin
						if (emit_done) begin
							state_q <= ST_IDLE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_RC0: begin
				bpf_q     <= frame_bits[FBW-1:3];
				prod1_q   <= P1W'(sample_rate_q) * P1W'(speed_q);
				tot_raw_q <= TRW'(track_q) * TRW'(frame_bits);
			end
			ST_RC1: begin
				prod2_q <= P2W'(prod1_q) * P2W'(bpf_q);
				total_q <= (tot_bytes > (TRW - 3)'({OW{1'b1}})) ? '1 : tot_bytes[OW-1:0];
			end
			ST_RC2: begin
				prod3_q <= P3W'(prod2_q) * P3W'(PERIOD_MS);
			end
			ST_RC3: begin
				div_cnt_q <= CW'(QW - 1);
				div_quo_q <= '0;
				div_den_q <= bpf_den;
				bytes_q   <= rc_bytes;
				div_rem_q <= DW'(rc_bytes);
				if (bpf_q == '0) begin
					packet_size_q <= '0;
				end
			end
			ST_DIV2: begin
				div_rem_q <= div_rem_nxt;
				div_den_q <= div_den_q >> 1;
				div_quo_q <= div_quo_nxt;
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_last) begin
					packet_size_q <= bytes_q - QW'(div_rem_nxt);
				end
			end
			ST_TICK: begin
				off_q      <= read_index_q;
				fits_q     <= tk_fits;
				seg_amt_q  <= tk_fits ? lapp_pkg::AMOUNT_W'(packet_size_q)
				                      : lapp_pkg::sat_amount(tk_tail);
				head_amt_q <= lapp_pkg::sat_amount(tk_head);
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/looping_audio_packet_pacer.sv
// Top level of the looping audio packet pacer.
// Items enter through a queue-style port: an item transfers when push is high
// and full is low. Mode 0 is a tick, 1 toggles pause, 2 restarts at offset zero
// and 3 sets the speed, saturated to 75..150 percent.
// Results leave through a queue-style port: the oldest result is shown while
// empty is low and transfers when pop is high. A tick gives one to four results
// (track start, audio segments), with last set on its final one.
// Registers are written with cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce. Every
// register write or speed change recomputes the packet size: states ST_RC0 to ST_RC3
// form the products, with the division by 100000 done as a reciprocal multiply, then
// ST_DIV2 runs a one-bit-per-cycle division by the frame size. A tick passes through
// ST_TICK and emits its results from ST_EMIT; pause and restart act in the idle state.
// Reset clears both queues, loads the register defaults and starts a packet size
// computation before the first item is executed.
// When the receiver stalls, the result queue fills and then the command queue,
// after which full is raised; nothing is lost.
module looping_audio_packet_pacer #(
	parameter int unsigned MAX_PACKET_BYTES = 4096,
	parameter int unsigned PERIOD_MS        = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lapp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lapp_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic [lapp_pkg::MODE_W-1:0]    mode,
	input  logic [lapp_pkg::SPEED_W-1:0]   speed_percent,
	output logic                           empty,
	input  logic                           pop,
	output logic [lapp_pkg::KIND_W-1:0]    kind,
	output logic [lapp_pkg::OFFSET_W-1:0]  byte_offset,
	output logic [lapp_pkg::AMOUNT_W-1:0]  amount,
	output logic                           last
);

	localparam int unsigned CMD_W = $bits(lapp_pkg::cmd_t);
	localparam int unsigned RES_W = $bits(lapp_pkg::result_t);

	lapp_pkg::cmd_t    cmd_in;
	lapp_pkg::cmd_t    cmd_out;
	lapp_pkg::result_t res_in;
	lapp_pkg::result_t res_out;
	logic [CMD_W-1:0]  cmd_bits;
	logic [RES_W-1:0]  res_bits;
	logic              cmd_empty;
	logic              cmd_pop;
	logic              res_push;
	logic              res_full;

	lapp_front u_front (
		.mode          (mode),
		.speed_percent (speed_percent),
		.cmd           (cmd_in)
	);

	lapp_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (4)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_bits),
		.empty   (cmd_empty)
	);

	assign cmd_out = lapp_pkg::cmd_t'(cmd_bits);

	lapp_back #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES),
		.PERIOD_MS        (PERIOD_MS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_out),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	lapp_fifo #(
		.WIDTH (RES_W),
		.DEPTH (4)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_bits),
		.empty   (empty)
	);

	assign res_out     = lapp_pkg::result_t'(res_bits);
	assign kind        = res_out.kind;
	assign byte_offset = res_out.byte_offset;
	assign amount      = res_out.amount;
	assign last        = res_out.last;

endmodule
